// ===== rtl/core/lvnt_pkg.sv =====
// ----------------------------------------------------------------------------
// lvnt_pkg: shared types and codes for the local value number table
// Action codes, register indexes, controller states and the flag group
// that travels with a search request down the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package lvnt_pkg;

    localparam int OPCODE_WIDTH = 8;
    localparam int ACTION_WIDTH = 2;
    localparam int CFG_IDX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH = 8;

    typedef enum logic [ACTION_WIDTH-1:0] {
        ACT_INSN       = 2'd0,
        ACT_INSN_CLEAR = 2'd1,
        ACT_CLEAR      = 2'd2,
        ACT_RESERVED   = 2'd3
    } lvnt_action_t;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_BINOP_LOW  = 2'd0,
        CFG_BINOP_HIGH = 2'd1,
        CFG_MOVE_OP    = 2'd2,
        CFG_UNUSED     = 2'd3
    } lvnt_cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } lvnt_state_t;

    // Flags carried with a search request from cell to cell
    typedef struct packed {
        logic live;    // a request occupies this slot
        logic found;   // an earlier cell matched the key
        logic placed;  // the key was stored in an earlier cell
    } lvnt_tok_t;

endpackage

`default_nettype wire

// ===== rtl/core/lvnt_cell.sv =====
// ----------------------------------------------------------------------------
// lvnt_cell: one table entry of the value number chain
// Holds one key and its value id; compares the passing request, stores it
// at the first free cell, and hands the request on through its output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lvnt_cell #(
    parameter int ID_WIDTH = 16
) (
    input  wire                                     aclk,
    input  wire                                     aresetn,
    input  wire                                     clear_tbl,
    input  lvnt_pkg::lvnt_tok_t                     tok_in,
    input  wire  [lvnt_pkg::OPCODE_WIDTH-1:0]       op_in,
    input  wire  [ID_WIDTH-1:0]                     a_in,
    input  wire  [ID_WIDTH-1:0]                     b_in,
    input  wire  [ID_WIDTH-1:0]                     d_in,
    input  wire  [ID_WIDTH-1:0]                     val_in,
    output lvnt_pkg::lvnt_tok_t                     tok_out,
    output logic [lvnt_pkg::OPCODE_WIDTH-1:0]       op_out,
    output logic [ID_WIDTH-1:0]                     a_out,
    output logic [ID_WIDTH-1:0]                     b_out,
    output logic [ID_WIDTH-1:0]                     d_out,
    output logic [ID_WIDTH-1:0]                     val_out
);

    logic                               valid_reg;
    logic [lvnt_pkg::OPCODE_WIDTH-1:0]  key_op_reg;
    logic [ID_WIDTH-1:0]                key_a_reg;
    logic [ID_WIDTH-1:0]                key_b_reg;
    logic [ID_WIDTH-1:0]                key_val_reg;

    lvnt_pkg::lvnt_tok_t                tok_reg;
    lvnt_pkg::lvnt_tok_t                tok_next;
    logic [ID_WIDTH-1:0]                val_next;

    logic match;
    logic hit_here;
    logic place_here;

    assign match = valid_reg && (key_op_reg == op_in) && (key_a_reg == a_in)
                   && (key_b_reg == b_in);
    assign hit_here = tok_in.live && !tok_in.found && match;
    // cells fill in order, so the first empty cell reached is the next slot
    assign place_here = tok_in.live && !tok_in.found && !tok_in.placed && !valid_reg;

    always_comb begin
        tok_next.live   = tok_in.live;
        tok_next.found  = tok_in.found | hit_here;
        tok_next.placed = tok_in.placed | place_here;
        val_next        = hit_here ? key_val_reg : val_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end else begin
            tok_reg <= tok_next;
            if (clear_tbl) begin
                valid_reg <= 1'b0;
            end else if (place_here) begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (place_here) begin
            key_op_reg  <= op_in;
            key_a_reg   <= a_in;
            key_b_reg   <= b_in;
            key_val_reg <= d_in;
        end
        op_out  <= op_in;
        a_out   <= a_in;
        b_out   <= b_in;
        d_out   <= d_in;
        val_out <= val_next;
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// ===== rtl/core/local_value_number_table_core.sv =====
// ----------------------------------------------------------------------------
// local_value_number_table_core: local value numbering over one basic block
// Each request is one instruction. An opcode inside binop_low..binop_high is
// looked up by (opcode, operand_a, operand_b) in a chain of TABLE_DEPTH
// cells; a hit turns it into move_opcode of the remembered value id with
// operand_b zeroed, a miss stores the key with dest_id at the next free
// cell, or raises overflow when every cell is in use. Other opcodes pass
// through. Action 1 clears the table after the instruction, actions 2 and
// 3 clear it and give no result. Timing: one request is in flight at a
// time. For a looked-up instruction cell 0 compares in the accept cycle,
// the request then moves down the chain to its tail, the controller
// captures the outcome there, and the outcome then loads the output
// register once it is free; a pass-through goes from accept straight to
// the output register load, and a clear-only request clears the table at
// its accept and gives no result. The next request is taken from the cycle
// after the output register loads. The output register lets the next
// request be accepted while a result waits on m_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module local_value_number_table_core #(
    parameter int TABLE_DEPTH = 64,
    parameter int ID_WIDTH    = 16
) (
    input  wire                                     aclk,
    input  wire                                     aresetn,

    // instruction requests
    input  wire                                     s_valid,
    output logic                                    s_ready,
    input  wire  [lvnt_pkg::ACTION_WIDTH-1:0]       s_action,
    input  wire  [lvnt_pkg::OPCODE_WIDTH-1:0]       s_opcode,
    input  wire  [ID_WIDTH-1:0]                     s_operand_a,
    input  wire  [ID_WIDTH-1:0]                     s_operand_b,
    input  wire  [ID_WIDTH-1:0]                     s_dest_id,

    // results
    output logic                                    m_valid,
    input  wire                                     m_ready,
    output logic [lvnt_pkg::OPCODE_WIDTH-1:0]       m_out_opcode,
    output logic [ID_WIDTH-1:0]                     m_out_operand_a,
    output logic [ID_WIDTH-1:0]                     m_out_operand_b,
    output logic [ID_WIDTH-1:0]                     m_out_dest,
    output logic                                    m_rewritten,
    output logic                                    m_overflow,

    // register writes
    input  wire                                     cfg_valid,
    output logic                                    cfg_ready,
    input  wire  [lvnt_pkg::CFG_IDX_WIDTH-1:0]      cfg_index,
    input  wire  [lvnt_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);

    // ------------------------------------------------------------------
    // configuration registers, always writable
    // ------------------------------------------------------------------
    logic [lvnt_pkg::OPCODE_WIDTH-1:0] binop_low_reg;
    logic [lvnt_pkg::OPCODE_WIDTH-1:0] binop_high_reg;
    logic [lvnt_pkg::OPCODE_WIDTH-1:0] move_opcode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            binop_low_reg   <= '0;
            binop_high_reg  <= '0;
            move_opcode_reg <= '0;
        end else if (cfg_valid) begin
            unique case (lvnt_pkg::lvnt_cfg_idx_t'(cfg_index))
                lvnt_pkg::CFG_BINOP_LOW:  binop_low_reg   <= cfg_data;
                lvnt_pkg::CFG_BINOP_HIGH: binop_high_reg  <= cfg_data;
                lvnt_pkg::CFG_MOVE_OP:    move_opcode_reg <= cfg_data;
                default: ;  // index beyond the register list: dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // request decode
    // ------------------------------------------------------------------
    logic s_accept;
    logic clear_only;
    logic in_range;

    assign s_accept   = s_valid && s_ready;
    assign clear_only = (s_action == lvnt_pkg::ACT_CLEAR) ||
                        (s_action == lvnt_pkg::ACT_RESERVED);
    // empty range (low > high) naturally matches nothing
    assign in_range   = (s_opcode >= binop_low_reg) && (s_opcode <= binop_high_reg);

    // ------------------------------------------------------------------
    // controller
    // ------------------------------------------------------------------
    lvnt_pkg::lvnt_state_t state_reg;
    lvnt_pkg::lvnt_state_t state_next;

    logic inject;      // launch a search into cell 0
    logic clear_tbl;   // drop every valid bit
    logic capture;     // search result reached the chain tail
    logic commit;      // load the output register

    lvnt_pkg::lvnt_tok_t tok_w [0:TABLE_DEPTH];
    logic [lvnt_pkg::OPCODE_WIDTH-1:0] op_w [0:TABLE_DEPTH];
    logic [ID_WIDTH-1:0] a_w   [0:TABLE_DEPTH];
    logic [ID_WIDTH-1:0] b_w   [0:TABLE_DEPTH];
    logic [ID_WIDTH-1:0] d_w   [0:TABLE_DEPTH];
    logic [ID_WIDTH-1:0] val_w [0:TABLE_DEPTH];

    // held copy of the accepted instruction
    logic                              insn_clear_reg;
    logic                              looked_up_reg;
    logic [lvnt_pkg::OPCODE_WIDTH-1:0] insn_op_reg;
    logic [ID_WIDTH-1:0]               insn_a_reg;
    logic [ID_WIDTH-1:0]               insn_b_reg;
    logic [ID_WIDTH-1:0]               insn_d_reg;

    // search outcome
    logic                              hit_reg;
    logic                              ovf_reg;
    logic [ID_WIDTH-1:0]               hit_val_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lvnt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        inject     = 1'b0;
        clear_tbl  = 1'b0;
        capture    = 1'b0;
        commit     = 1'b0;
        unique case (state_reg)
            lvnt_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    priority if (clear_only) begin
                        clear_tbl = 1'b1;
                    end else if (in_range) begin
                        inject     = 1'b1;
                        state_next = lvnt_pkg::ST_SEARCH;
                    end else begin
                        state_next = lvnt_pkg::ST_DONE;
                    end
                end
            end
            lvnt_pkg::ST_SEARCH: begin
                if (tok_w[TABLE_DEPTH].live) begin
                    capture    = 1'b1;
                    state_next = lvnt_pkg::ST_DONE;
                end
            end
            lvnt_pkg::ST_DONE: begin
                if (!m_valid || m_ready) begin
                    commit     = 1'b1;
                    // instruction then clear: the insert already happened
                    clear_tbl  = insn_clear_reg;
                    state_next = lvnt_pkg::ST_IDLE;
                end
            end
            default: state_next = lvnt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            insn_clear_reg <= (s_action == lvnt_pkg::ACT_INSN_CLEAR);
            looked_up_reg  <= in_range;
            insn_op_reg    <= s_opcode;
            insn_a_reg     <= s_operand_a;
            insn_b_reg     <= s_operand_b;
            insn_d_reg     <= s_dest_id;
        end
        if (capture) begin
            hit_reg     <= tok_w[TABLE_DEPTH].found;
            ovf_reg     <= !tok_w[TABLE_DEPTH].found && !tok_w[TABLE_DEPTH].placed;
            hit_val_reg <= val_w[TABLE_DEPTH];
        end
    end

    // ------------------------------------------------------------------
    // cell chain: one entry per cell, request moves one cell per cycle
    // ------------------------------------------------------------------
    assign tok_w[0].live   = inject;
    assign tok_w[0].found  = 1'b0;
    assign tok_w[0].placed = 1'b0;
    assign op_w[0]         = s_opcode;
    assign a_w[0]          = s_operand_a;
    assign b_w[0]          = s_operand_b;
    assign d_w[0]          = s_dest_id;
    assign val_w[0]        = '0;

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        lvnt_cell #(
            .ID_WIDTH (ID_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .clear_tbl (clear_tbl),
            .tok_in    (tok_w[i]),
            .op_in     (op_w[i]),
            .a_in      (a_w[i]),
            .b_in      (b_w[i]),
            .d_in      (d_w[i]),
            .val_in    (val_w[i]),
            .tok_out   (tok_w[i+1]),
            .op_out    (op_w[i+1]),
            .a_out     (a_w[i+1]),
            .b_out     (b_w[i+1]),
            .d_out     (d_w[i+1]),
            .val_out   (val_w[i+1])
        );
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic m_valid_reg;
    logic m_valid_next;
    logic hit_final;

    assign hit_final    = looked_up_reg && hit_reg;
    assign m_valid_next = commit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_out_opcode    <= hit_final ? move_opcode_reg : insn_op_reg;
            m_out_operand_a <= hit_final ? hit_val_reg : insn_a_reg;
            m_out_operand_b <= hit_final ? '0 : insn_b_reg;
            m_out_dest      <= insn_d_reg;
            m_rewritten     <= hit_final;
            m_overflow      <= looked_up_reg && ovf_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ===== dv/lvnt_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lvnt_checker: value-numbering predictor and result scoreboard
// Watches the request, result and register-write channels. Keeps its own
// table of (opcode, operand_a, operand_b) keys. Predicts each result when its
// request is accepted, and compares every returned result field by field.
// ----------------------------------------------------------------------------

module lvnt_checker #(
    parameter int TABLE_DEPTH = 64,
    parameter int ID_WIDTH    = 16
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,

    input  wire                                 s_valid,
    input  wire                                 s_ready,
    input  wire  [lvnt_pkg::ACTION_WIDTH-1:0]   s_action,
    input  wire  [lvnt_pkg::OPCODE_WIDTH-1:0]   s_opcode,
    input  wire  [ID_WIDTH-1:0]                 s_operand_a,
    input  wire  [ID_WIDTH-1:0]                 s_operand_b,
    input  wire  [ID_WIDTH-1:0]                 s_dest_id,

    input  wire                                 m_valid,
    input  wire                                 m_ready,
    input  wire  [lvnt_pkg::OPCODE_WIDTH-1:0]   m_out_opcode,
    input  wire  [ID_WIDTH-1:0]                 m_out_operand_a,
    input  wire  [ID_WIDTH-1:0]                 m_out_operand_b,
    input  wire  [ID_WIDTH-1:0]                 m_out_dest,
    input  wire                                 m_rewritten,
    input  wire                                 m_overflow,

    input  wire                                 cfg_valid,
    input  wire                                 cfg_ready,
    input  wire  [lvnt_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  wire  [lvnt_pkg::CFG_DATA_WIDTH-1:0] cfg_data,

    output int                                  fail_count,
    output int                                  pending,
    output int                                  result_count,
    output int                                  hit_count,
    output int                                  overflow_count
);

    typedef struct packed {
        logic [lvnt_pkg::OPCODE_WIDTH-1:0] opcode;
        logic [ID_WIDTH-1:0]               operand_a;
        logic [ID_WIDTH-1:0]               operand_b;
        logic [ID_WIDTH-1:0]               dest;
        logic                              rewritten;
        logic                              overflow;
    } insn_result_t;

    insn_result_t rewrite_q[$];

    // shadow table
    logic                              slot_live [TABLE_DEPTH];
    logic [lvnt_pkg::OPCODE_WIDTH-1:0] slot_op   [TABLE_DEPTH];
    logic [ID_WIDTH-1:0]               slot_a    [TABLE_DEPTH];
    logic [ID_WIDTH-1:0]               slot_b    [TABLE_DEPTH];
    logic [ID_WIDTH-1:0]               slot_val  [TABLE_DEPTH];
    int                                slots_used;

    logic [7:0] vn_low, vn_high, move_op;
    int mismatches, results, hits, overflows;

    task automatic clear_slots();
        int i;
        for (i = 0; i < TABLE_DEPTH; i++) slot_live[i] = 1'b0;
        slots_used = 0;
    endtask

    task automatic predict_rewrite(input lvnt_pkg::lvnt_action_t act,
                                   input logic [lvnt_pkg::OPCODE_WIDTH-1:0] op,
                                   input logic [ID_WIDTH-1:0] a,
                                   input logic [ID_WIDTH-1:0] b,
                                   input logic [ID_WIDTH-1:0] d);
        insn_result_t r;
        bit           found;
        int           i;
        if (act == lvnt_pkg::ACT_CLEAR || act == lvnt_pkg::ACT_RESERVED) begin
            clear_slots();
            return;
        end
        r = '{opcode: op, operand_a: a, operand_b: b, dest: d,
              rewritten: 1'b0, overflow: 1'b0};
        if (op >= vn_low && op <= vn_high) begin
            found = 1'b0;
            for (i = 0; i < TABLE_DEPTH; i++) begin
                if (!found && slot_live[i] && slot_op[i] == op &&
                    slot_a[i] == a && slot_b[i] == b) begin
                    found       = 1'b1;
                    r.opcode    = move_op;
                    r.operand_a = slot_val[i];
                    r.operand_b = '0;
                    r.rewritten = 1'b1;
                end
            end
            if (!found) begin
                if (slots_used < TABLE_DEPTH) begin
                    slot_live[slots_used] = 1'b1;
                    slot_op[slots_used]   = op;
                    slot_a[slots_used]    = a;
                    slot_b[slots_used]    = b;
                    slot_val[slots_used]  = d;
                    slots_used++;
                end else begin
                    r.overflow = 1'b1;
                end
            end
        end
        rewrite_q.push_back(r);
        // insert first, then the block boundary
        if (act == lvnt_pkg::ACT_INSN_CLEAR) clear_slots();
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_slots();
            vn_low  = '0;
            vn_high = '0;
            move_op = '0;
            rewrite_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (lvnt_pkg::lvnt_cfg_idx_t'(cfg_index))
                    lvnt_pkg::CFG_BINOP_LOW:  vn_low  = cfg_data;
                    lvnt_pkg::CFG_BINOP_HIGH: vn_high = cfg_data;
                    lvnt_pkg::CFG_MOVE_OP:    move_op = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (rewrite_q.size() == 0) begin
                    $error("result with no request outstanding: opcode 0x%0h dest 0x%0h",
                           m_out_opcode, m_out_dest);
                    mismatches++;
                end else begin
                    insn_result_t w;
                    w = rewrite_q.pop_front();
                    check_field("out_opcode", 32'(w.opcode), 32'(m_out_opcode));
                    check_field("out_operand_a", 32'(w.operand_a), 32'(m_out_operand_a));
                    check_field("out_operand_b", 32'(w.operand_b), 32'(m_out_operand_b));
                    check_field("out_dest", 32'(w.dest), 32'(m_out_dest));
                    check_field("rewritten", 32'(w.rewritten), 32'(m_rewritten));
                    check_field("overflow", 32'(w.overflow), 32'(m_overflow));
                    results++;
                    hits      += int'(w.rewritten);
                    overflows += int'(w.overflow);
                end
            end
            if (s_valid && s_ready)
                predict_rewrite(lvnt_pkg::lvnt_action_t'(s_action), s_opcode, s_operand_a,
                                s_operand_b, s_dest_id);
        end
        fail_count     <= mismatches;
        pending        <= rewrite_q.size();
        result_count   <= results;
        hit_count      <= hits;
        overflow_count <= overflows;
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: local value number table core
// Drives instruction requests and register writes, with random idling on
// both channels and one long output stall. A directed prologue covers the
// key corners; random basic blocks follow under several range settings.
// Prediction and checking live in lvnt_checker.
// ----------------------------------------------------------------------------

module testbench;

    localparam int TABLE_DEPTH = 64;
    localparam int ID_WIDTH    = 16;
    localparam int LIMIT       = 2_000_000;  // cycles, far above a clean run
    localparam int STALL_LEN   = 400;        // long output hold-off
    localparam int DIRECTED    = 22;         // requests in the prologue, clears included
    localparam int PER_PHASE   = 395;        // instructions per random phase

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // request channel
    logic                              s_valid     = 1'b0;
    wire                               s_ready;
    logic [lvnt_pkg::ACTION_WIDTH-1:0] s_action    = lvnt_pkg::ACT_INSN;
    logic [lvnt_pkg::OPCODE_WIDTH-1:0] s_opcode    = '0;
    logic [ID_WIDTH-1:0]               s_operand_a = '0;
    logic [ID_WIDTH-1:0]               s_operand_b = '0;
    logic [ID_WIDTH-1:0]               s_dest_id   = '0;

    // result channel
    wire                               m_valid;
    logic                              m_ready = 1'b0;
    wire [lvnt_pkg::OPCODE_WIDTH-1:0]  m_out_opcode;
    wire [ID_WIDTH-1:0]                m_out_operand_a;
    wire [ID_WIDTH-1:0]                m_out_operand_b;
    wire [ID_WIDTH-1:0]                m_out_dest;
    wire                               m_rewritten;
    wire                               m_overflow;

    // register writes
    logic                                cfg_valid = 1'b0;
    wire                                 cfg_ready;
    logic [lvnt_pkg::CFG_IDX_WIDTH-1:0]  cfg_index = lvnt_pkg::CFG_BINOP_LOW;
    logic [lvnt_pkg::CFG_DATA_WIDTH-1:0] cfg_data  = '0;

    int fail_count, pending, result_count, hit_count, overflow_count;

    int  cycles       = 0;
    int  instr_sent   = 0;  // instructions accepted, clears excluded
    int  settings     = 0;
    bit  stall_done   = 1'b0;
    logic [7:0] cur_low  = '0;
    logic [7:0] cur_high = '0;

    always #5 aclk = ~aclk;

    local_value_number_table_core #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_opcode        (s_opcode),
        .s_operand_a     (s_operand_a),
        .s_operand_b     (s_operand_b),
        .s_dest_id       (s_dest_id),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_opcode    (m_out_opcode),
        .m_out_operand_a (m_out_operand_a),
        .m_out_operand_b (m_out_operand_b),
        .m_out_dest      (m_out_dest),
        .m_rewritten     (m_rewritten),
        .m_overflow      (m_overflow),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    lvnt_checker #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_opcode        (s_opcode),
        .s_operand_a     (s_operand_a),
        .s_operand_b     (s_operand_b),
        .s_dest_id       (s_dest_id),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_opcode    (m_out_opcode),
        .m_out_operand_a (m_out_operand_a),
        .m_out_operand_b (m_out_operand_b),
        .m_out_dest      (m_out_dest),
        .m_rewritten     (m_rewritten),
        .m_overflow      (m_overflow),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .result_count    (result_count),
        .hit_count       (hit_count),
        .overflow_count  (overflow_count)
    );

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: ready runs with short and long gaps, plus one long
    // hold-off once traffic is going so the core backs up onto s_ready.
    initial begin : result_sink
        int r;
        @(posedge aclk);
        forever begin
            if (!stall_done && instr_sent >= 300) begin
                m_ready <= 1'b0;
                repeat (STALL_LEN) @(posedge aclk);
                stall_done = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                m_ready <= 1'b1;
                repeat (r < 85 ? $urandom_range(1, 30) : $urandom_range(100, 300))
                    @(posedge aclk);
                r = $urandom_range(0, 99);
                m_ready <= 1'b0;
                if (r < 80)      repeat ($urandom_range(1, 3)) @(posedge aclk);
                else if (r < 95) repeat ($urandom_range(4, 15)) @(posedge aclk);
                else             repeat ($urandom_range(30, 120)) @(posedge aclk);
            end
        end
    end

    // One request; returns at the accepting edge, then maybe idles.
    // valid is only dropped when a gap follows, so back-to-back requests
    // never see a low/high pair in the same step.
    task automatic send_req(input lvnt_pkg::lvnt_action_t act, input logic [7:0] op,
                            input logic [15:0] a, input logic [15:0] b,
                            input logic [15:0] d);
        int r;
        s_valid     <= 1'b1;
        s_action    <= act;
        s_opcode    <= op;
        s_operand_a <= a;
        s_operand_b <= b;
        s_dest_id   <= d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (act == lvnt_pkg::ACT_INSN || act == lvnt_pkg::ACT_INSN_CLEAR) instr_sent++;
        r = $urandom_range(0, 99);
        if (r >= 60) begin
            s_valid <= 1'b0;
            if (r < 95) repeat ($urandom_range(1, 4)) @(posedge aclk);
            else        repeat ($urandom_range(20, 80)) @(posedge aclk);
        end
    endtask

    // Drain: all results back, then enough cycles for a trailing clear
    // to retire before registers change.
    task automatic wait_table_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (TABLE_DEPTH + 4) @(posedge aclk);
    endtask

    // Register writes back to back; optionally pokes the spare index too.
    task automatic write_regs(input logic [7:0] lo, input logic [7:0] hi,
                              input logic [7:0] mv, input bit with_spare);
        lvnt_pkg::lvnt_cfg_idx_t idx [4];
        logic [7:0]              val [4];
        int                      k;
        idx[0] = lvnt_pkg::CFG_BINOP_LOW;  val[0] = lo;
        idx[1] = lvnt_pkg::CFG_BINOP_HIGH; val[1] = hi;
        idx[2] = lvnt_pkg::CFG_MOVE_OP;    val[2] = mv;
        idx[3] = lvnt_pkg::CFG_UNUSED;     val[3] = 8'($urandom);
        for (k = 0; k < (with_spare ? 4 : 3); k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        cur_low  = lo;
        cur_high = hi;
        settings++;
    endtask

    // Opcode inside the live range, or anything when the range is empty.
    function automatic logic [7:0] pick_binop();
        if (cur_low <= cur_high) return 8'($urandom_range(cur_high, cur_low));
        return 8'($urandom);
    endfunction

    // One basic block. Keys come from a local pool so repeats give hits;
    // a fill block is mostly fresh keys and runs the table past full.
    task automatic run_block(input int len, input bit fill);
        logic [7:0]              pool_op [128];
        logic [15:0]             pool_a  [128];
        logic [15:0]             pool_b  [128];
        int                      npool;
        int                      i, j, r;
        logic [7:0]              op;
        logic [15:0]             a, b;
        lvnt_pkg::lvnt_action_t  act;
        npool = 0;
        for (i = 0; i < len; i++) begin
            act = (i == len - 1 && $urandom_range(0, 1)) ? lvnt_pkg::ACT_INSN_CLEAR
                                                          : lvnt_pkg::ACT_INSN;
            r = $urandom_range(0, 99);
            if (r < 6) begin
                // noise: any action, any fields
                send_req(lvnt_pkg::lvnt_action_t'($urandom_range(0, 3)), 8'($urandom),
                         16'($urandom), 16'($urandom), 16'($urandom));
                continue;
            end
            if (npool > 0 && r < (fill ? 20 : 45)) begin
                j  = $urandom_range(0, npool - 1);
                op = pool_op[j];
                a  = pool_a[j];
                b  = pool_b[j];
                // near miss: one operand bit off
                if (r % 5 == 0) begin
                    if (r % 2) a ^= 16'(1) << $urandom_range(0, 15);
                    else       b ^= 16'(1) << $urandom_range(0, 15);
                end
            end else begin
                op = (fill || r < 90) ? pick_binop() : 8'($urandom);
                a  = 16'($urandom);
                b  = 16'($urandom);
                if (npool < 128) begin
                    pool_op[npool] = op;
                    pool_a[npool]  = a;
                    pool_b[npool]  = b;
                    npool++;
                end
            end
            send_req(act, op, a, b, 16'($urandom));
        end
        // block boundary as a bare clear, sometimes via the reserved code
        if ($urandom_range(0, 1))
            send_req($urandom_range(0, 1) ? lvnt_pkg::ACT_CLEAR : lvnt_pkg::ACT_RESERVED,
                     8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial begin : stimulus
        int         p, phase_end;
        bit         fill, first;
        logic [7:0] lo, hi, mv, t;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed: full range, distinctive move opcode ----
        write_regs(8'h00, 8'hFF, 8'hA5, 1'b1);
        send_req(lvnt_pkg::ACT_INSN, 8'h00, 16'h0000, 16'h0000, 16'h1111);  // miss, lowest
        send_req(lvnt_pkg::ACT_INSN, 8'h00, 16'h0000, 16'h0000, 16'h2222);  // hit
        send_req(lvnt_pkg::ACT_INSN, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);  // miss, highest
        send_req(lvnt_pkg::ACT_INSN, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h0000);  // hit
        send_req(lvnt_pkg::ACT_INSN, 8'hFF, 16'hFFFF, 16'hFFFE, 16'h0005);  // operand_b differs
        send_req(lvnt_pkg::ACT_INSN, 8'hFE, 16'hFFFF, 16'hFFFF, 16'h0006);  // opcode differs
        // insert, then clear
        send_req(lvnt_pkg::ACT_INSN_CLEAR, 8'h40, 16'h1234, 16'h5678, 16'h9ABC);
        send_req(lvnt_pkg::ACT_INSN, 8'h00, 16'h0000, 16'h0000, 16'h0007);  // gone after clear
        send_req(lvnt_pkg::ACT_INSN, 8'h40, 16'h1234, 16'h5678, 16'h0008);  // miss again
        // hit, then clear
        send_req(lvnt_pkg::ACT_INSN_CLEAR, 8'h40, 16'h1234, 16'h5678, 16'h0009);
        send_req(lvnt_pkg::ACT_INSN, 8'h40, 16'h1234, 16'h5678, 16'h000A);
        send_req(lvnt_pkg::ACT_CLEAR, 8'h40, 16'h1234, 16'h5678, 16'h000B);     // clear only
        send_req(lvnt_pkg::ACT_INSN, 8'h40, 16'h1234, 16'h5678, 16'h000C);
        send_req(lvnt_pkg::ACT_RESERVED, 8'h40, 16'h1234, 16'h5678, 16'h000D);  // clears too
        send_req(lvnt_pkg::ACT_INSN, 8'h40, 16'h1234, 16'h5678, 16'h000E);
        send_req(lvnt_pkg::ACT_INSN, 8'h40, 16'h1234, 16'h5678, 16'h000F);      // hit

        // ---- directed: range edges ----
        wait_table_idle();
        write_regs(8'h20, 8'h30, 8'hFF, 1'b0);
        send_req(lvnt_pkg::ACT_INSN, 8'h1F, 16'h0001, 16'h0002, 16'h0003);  // below range
        send_req(lvnt_pkg::ACT_INSN, 8'h1F, 16'h0001, 16'h0002, 16'h0003);  // still passes
        send_req(lvnt_pkg::ACT_INSN, 8'h20, 16'h0001, 16'h0002, 16'h0003);  // low edge
        send_req(lvnt_pkg::ACT_INSN, 8'h30, 16'h0001, 16'h0002, 16'h0004);  // high edge
        send_req(lvnt_pkg::ACT_INSN, 8'h30, 16'h0001, 16'h0002, 16'h0005);  // hit, max move op
        send_req(lvnt_pkg::ACT_INSN, 8'h31, 16'h0001, 16'h0002, 16'h0006);  // above range

        // ---- random basic blocks under several settings ----
        for (p = 1; p <= 5; p++) begin
            wait_table_idle();
            case (p)
                1: begin lo = 8'h00; hi = 8'hFF; mv = 8'h00; end
                2: begin lo = 8'hFF; hi = 8'hFF; mv = 8'hFF; end
                3: begin lo = 8'hC0; hi = 8'h3F; mv = 8'h3C; end  // empty range
                4: begin
                    lo = 8'($urandom);
                    hi = 8'($urandom);
                    mv = 8'($urandom);
                    if (lo > hi) begin
                        t  = lo;
                        lo = hi;
                        hi = t;
                    end
                end
                default: begin lo = 8'h00; hi = 8'h00; mv = 8'h80; end
            endcase
            write_regs(lo, hi, mv, 1'b0);
            phase_end = DIRECTED + PER_PHASE * p;
            first = 1'b1;
            while (instr_sent < phase_end) begin
                fill  = first || ($urandom_range(0, 5) == 0);
                first = 1'b0;
                run_block(fill ? $urandom_range(72, 110) : $urandom_range(1, 40), fill);
            end
        end

        wait_table_idle();
        $display("Ran %0d instructions over %0d register settings, %0d results checked.",
                 instr_sent, settings, result_count);
        $display("%0d rewritten to moves, %0d misses dropped on a full table.",
                 hit_count, overflow_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/lvnt_pkg.sv
rtl/core/lvnt_cell.sv
rtl/core/local_value_number_table_core.sv
dv/lvnt_checker.sv
dv/testbench.sv
